// ----- hw/rtl/weighted_random_pick_defines.svh -----
// Assertion macros used by the weighted random pick top level.
// No dependencies; include this file by its bare name.
`ifndef WEIGHTED_RANDOM_PICK_DEFINES_SVH
`define WEIGHTED_RANDOM_PICK_DEFINES_SVH

`ifndef SYNTHESIS
`define WRP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("weighted_random_pick: assertion failed");
`define WRP_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("weighted_random_pick: assertion failed");
`else
`define WRP_ASSERT(label, clk, rst, prop)
`define WRP_ASSERT_NEXT(label, clk, rst, pre, post)
`endif

`endif

// ----- hw/rtl/wrp_pkg.sv -----
// Types and constants of the weighted random pick block.
// No dependencies; used by wrp_cell and weighted_random_pick.
package wrp_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam int OP_W        = 2;
   localparam int WEIGHT_W    = 16;
   localparam int CHANCE_W    = 7;
   localparam int POS_W       = 14;
   localparam int TOTAL_W     = 20;
   localparam int PROD_W      = POS_W + TOTAL_W;
   // One weight scaled by the draw range fits in 30 bits.
   localparam int SCALED_W    = 30;
   // Scaled running sums over up to 64 entries fit in 36 bits.
   localparam int SUM_W       = 36;

   localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
   localparam logic [OP_W-1:0] OP_PICK  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'd256;
   localparam logic [TOTAL_W-1:0]  TOTAL_MAX  = 20'hFFFFF;
   localparam logic [POS_W-1:0]    DRAW_SCALE = 14'd10000;
   localparam logic [CHANCE_W-1:0] CHANCE_RESET = 7'd100;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic                 run;
      logic [WEIGHT_W-1:0]  weight;
      logic [SUM_W-1:0]     target;
   } wrp_bcast_type;

   // Token and running sum handed from one cell to the next.
   typedef struct packed {
      logic              active;
      logic [SUM_W-1:0]  cum;
   } wrp_link_type;

endpackage

// ----- hw/rtl/weighted_random_pick.sv -----
// Top level of the weighted random pick block: controller and the chain of cells.
// Depends on wrp_pkg, wrp_cell and weighted_random_pick_defines.svh.
//
//   Port group   Direction  Handshake                Contents
//   req_*        in         req_valid / req_ready    operation, weight, two draws
//   rsp_*        out        rsp_valid / rsp_ready    accepted, picked, index, count
//   csr_*        in         csr_write_enable         appear chance percent
//
// An add, a clear or a refused pick goes from execute straight to done. A pick
// first forms the target in the multiply state, then in the scan state the token
// walks one cell per cycle until the cumulative sum reaches it.
// Only one word is in flight; req_ready is high in the idle state only, while
// a finished word may still wait in the output register.
// Reset is synchronous and clears the table count, the total and the handshake.
`include "weighted_random_pick_defines.svh"

module weighted_random_pick (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [wrp_pkg::OP_W-1:0]       req_operation,
   input  logic signed [wrp_pkg::WEIGHT_W-1:0] req_weight_in,
   input  logic [wrp_pkg::CHANCE_W-1:0]   req_chance_draw,
   input  logic [wrp_pkg::POS_W-1:0]      req_position_draw,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_accepted,
   output logic                           rsp_picked,
   output logic [3:0]                     rsp_picked_index,
   output logic [4:0]                     rsp_entries_held,
   input  logic                           csr_write_enable,
   input  logic [wrp_pkg::CHANCE_W-1:0]   csr_write_data
);
   import wrp_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_SCAN = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [OP_W-1:0]      op_ff;
   logic [WEIGHT_W-1:0]  weight_ff;
   logic [CHANCE_W-1:0]  chance_ff;
   logic [POS_W-1:0]     pos_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [CHANCE_W-1:0]  appear_ff;
   logic [SUM_W-1:0]     target_ff, target_in;
   logic [IDX_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                 res_acc_ff, res_acc_in;
   logic                 res_pick_ff, res_pick_in;
   logic [IDX_W-1:0]     res_idx_ff, res_idx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_acc_ff;
   logic                 rsp_pick_ff;
   logic [IDX_W-1:0]     rsp_idx_ff;
   logic [CNT_W-1:0]     rsp_held_ff;

   logic                 req_take;
   logic                 out_load;
   logic                 wr_en;
   logic                 seed;
   logic [WEIGHT_W-1:0]  weight_eff;
   logic [TOTAL_W:0]     total_sum;
   logic [PROD_W-1:0]    prod;
   logic                 last_entry;
   logic                 hit_any;
   logic [MAX_ENTRIES-1:0] hit_vec;
   logic [MAX_ENTRIES-1:0] wr_sel;
   wrp_bcast_type        bcast;
   wrp_link_type         link_seed;
   wrp_link_type         links_out [MAX_ENTRIES];

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // A zero or negative weight is stored as 1.0 in Q8.8.
   assign weight_eff = ((weight_ff == '0) || weight_ff[WEIGHT_W-1]) ? WEIGHT_ONE : weight_ff;
   assign total_sum  = {1'b0, total_ff} + (TOTAL_W+1)'(weight_eff);

   // Target is position_draw times the total; every cell compares against it.
   assign prod = pos_ff * total_ff;

   assign hit_any    = |hit_vec;
   assign last_entry = (CNT_W'(scan_idx_ff) + CNT_W'(1)) == count_ff;
   assign seed       = (state_ff == ST_SCAN) && (scan_idx_ff == '0);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      target_in    = target_ff;
      scan_idx_in  = scan_idx_ff;
      res_acc_in   = res_acc_ff;
      res_pick_in  = res_pick_ff;
      res_idx_in   = res_idx_ff;
      wr_en        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               res_acc_in  = 1'b0;
               res_pick_in = 1'b0;
               res_idx_in  = '0;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            unique case (op_ff)
               OP_ADD: begin
                  // A full table refuses the add and leaves everything as is.
                  if (count_ff < CNT_W'(MAX_ENTRIES)) begin
                     wr_en      = 1'b1;
                     count_in   = count_ff + CNT_W'(1);
                     total_in   = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
                     res_acc_in = 1'b1;
                  end
               end
               OP_PICK: begin
                  if ((count_ff != '0) && (chance_ff < appear_ff)) begin
                     state_in = ST_MUL;
                  end
               end
               OP_CLEAR: begin
                  count_in   = '0;
                  total_in   = '0;
                  res_acc_in = 1'b1;
               end
               default: begin
                  state_in = ST_DONE;
               end
            endcase
         end
         ST_MUL: begin
            target_in   = SUM_W'(prod);
            scan_idx_in = '0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            // A draw beyond the range may find no hit; the last entry is taken then.
            if (hit_any || last_entry) begin
               res_pick_in = 1'b1;
               res_idx_in  = scan_idx_ff;
               state_in    = ST_DONE;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         appear_ff    <= CHANCE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            appear_ff <= csr_write_data;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff     <= req_operation;
         weight_ff <= req_weight_in;
         chance_ff <= req_chance_draw;
         pos_ff    <= req_position_draw;
      end
      target_ff   <= target_in;
      scan_idx_ff <= scan_idx_in;
      res_acc_ff  <= res_acc_in;
      res_pick_ff <= res_pick_in;
      res_idx_ff  <= res_idx_in;
      if (out_load) begin
         rsp_acc_ff  <= res_acc_ff;
         rsp_pick_ff <= res_pick_ff;
         rsp_idx_ff  <= res_idx_ff;
         rsp_held_ff <= count_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_acc_ff;
   assign rsp_picked       = rsp_pick_ff;
   assign rsp_picked_index = 4'(rsp_idx_ff);
   assign rsp_entries_held = 5'(rsp_held_ff);

   // The cells only see the token while a scan runs; otherwise it is flushed.
   assign bcast.run    = (state_ff == ST_SCAN);
   assign bcast.weight = weight_eff;
   assign bcast.target = target_ff;

   assign link_seed.active = seed;
   assign link_seed.cum    = '0;

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      assign wr_sel[i] = wr_en && (count_ff[IDX_W-1:0] == IDX_W'(i));
      if (i == 0) begin : g_first
         wrp_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .wr_en    (wr_sel[i]),
            .bcast    (bcast),
            .link_in  (link_seed),
            .link_out (links_out[i]),
            .hit      (hit_vec[i])
         );
      end else begin : g_next
         wrp_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .wr_en    (wr_sel[i]),
            .bcast    (bcast),
            .link_in  (links_out[i-1]),
            .link_out (links_out[i]),
            .hit      (hit_vec[i])
         );
      end
   end

   // Only the cell holding the token can report a hit.
   `WRP_ASSERT(a_single_hit, clock, reset, $onehot0(hit_vec))
   `WRP_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_ENTRIES))
   `WRP_ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && req_ready, state_ff == ST_EXEC)
   `WRP_ASSERT(a_index_bound, clock, reset, !(rsp_valid && rsp_picked) || (rsp_picked_index < rsp_entries_held))
   // The token leaves the end of the chain only when every entry is in use.
   `WRP_ASSERT(a_token_end, clock, reset, !links_out[MAX_ENTRIES-1].active || (count_ff == CNT_W'(MAX_ENTRIES)))

endmodule

// ----- hw/rtl/wrp_cell.sv -----
// One cell of the weight chain: holds a scaled weight and extends the running sum.
// Depends on wrp_pkg.
module wrp_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  wrp_pkg::wrp_bcast_type bcast,
   input  wrp_pkg::wrp_link_type  link_in,
   output wrp_pkg::wrp_link_type  link_out,
   output logic                  hit
);
   import wrp_pkg::*;

   logic [SCALED_W-1:0] scaled_ff;
   logic [SUM_W-1:0]    sum;
   logic                active_ff;
   logic                active_in;
   logic [SUM_W-1:0]    cum_ff;

   // The weight is stored already multiplied by the draw range.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         scaled_ff <= SCALED_W'(bcast.weight) * SCALED_W'(DRAW_SCALE);
      end
   end

   assign sum       = link_in.cum + SUM_W'(scaled_ff);
   assign hit       = bcast.run && link_in.active && (bcast.target <= sum);
   assign active_in = bcast.run && link_in.active && !hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      cum_ff <= sum;
   end

   assign link_out.active = active_ff;
   assign link_out.cum    = cum_ff;

endmodule
